@@ hw/rtl/chsg_pkg.sv @@
// package: types and constants for the clock hand segment generator
`timescale 1ns / 1ps
package chsg_pkg;

	// bhaskara constants
	localparam int unsigned BHASK_C    = 40500;
	localparam int unsigned DEG_FULL   = 360;
	localparam int unsigned DEG_HALF   = 180;
	localparam int unsigned DEG_QUART  = 90;
	// multiple of 360 above 32768 that lifts any 16-bit signed angle to a positive value
	localparam int unsigned ANG_OFS    = 33120;
	// floor(2^24 / 360), reciprocal for the mod-360 reduction
	localparam int unsigned RECIP_360  = 46603;
	localparam int unsigned QBITS      = 11;
	localparam int unsigned DIV_STAGES = 11;

	// payload that rides along the pipeline
	typedef struct packed {
		logic [11:0] cx;
		logic [11:0] cy;
		logic [10:0] len;
		logic [2:0]  half;
		logic [31:0] colour;
	} item_t;

	// truncate a Q10 product toward zero
	function automatic logic signed [13:0] trunc_q10(input logic signed [23:0] p);
		logic signed [23:0] b;
		b = p + (p[23] ? 24'sd1023 : 24'sd0);
		return 14'(b >>> 10);
	endfunction

endpackage

@@ hw/rtl/clock_hand_segment_generator.sv @@
// clock hand segment generator: angle reduction, bhaskara sine, tip and segment emission
//
// input channel in_valid/in_ready carries one hand word: centre, length, angle,
// thickness and colour. output channel out_valid/out_ready carries one segment
// word per offset k = -h..+h (h = thickness/2), in rising k, last_segment on k = +h.
// the front end is a 17-stage pipeline: two stages reduce the angle mod 360 by a
// reciprocal multiply, one folds and forms x = r*(180-r), one forms numerator and
// denominator, eleven restoring divider stages give one quotient bit each for
// sine and cosine, and two stages scale by the length and form the tip.
// the segment emitter makes one segment a cycle while the receiver takes them; it
// holds one hand at a time and takes the next only after that hand's last segment,
// so that loop sets the sustained rate.
// reset clears all valid bits and the emitter; no result is pending after reset.
// when the receiver stalls the output word holds, the emitter waits and the
// whole front pipeline freezes once its last stage holds a waiting hand.
`timescale 1ns / 1ps
module clock_hand_segment_generator
	import chsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [11:0]        centre_x,
	input  logic [11:0]        centre_y,
	input  logic [10:0]        hand_length,
	input  logic signed [15:0] angle_deg,
	input  logic [3:0]         thickness,
	input  logic [31:0]        line_colour,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [13:0] start_x,
	output logic signed [13:0] start_y,
	output logic signed [13:0] end_x,
	output logic signed [13:0] end_y,
	output logic [31:0]        segment_colour,
	output logic               last_segment
);

	logic en;

	// stage 1: lift angle, reciprocal multiply
	logic        v_s1;
	item_t       pl_s1;
	logic [16:0] a_s1;
	logic [31:0] prod_s1;
	logic [16:0] a_in;

	assign a_in = 17'(signed'(angle_deg)) + 17'(ANG_OFS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1   <= '{cx: centre_x, cy: centre_y, len: hand_length,
			             half: thickness[3:1], colour: line_colour};
			a_s1    <= a_in;
			prod_s1 <= 32'(a_in) * 32'(RECIP_360);
		end
	end

	// stage 2: remainder mod 360 with one correction
	logic        v_s2;
	item_t       pl_s2;
	logic [8:0]  rs_s2, rc_s2;
	logic [7:0]  q360;
	logic [16:0] rem0;
	logic [8:0]  rs_n;

	assign q360 = prod_s1[31:24];
	assign rem0 = a_s1 - 17'(q360) * 17'(DEG_FULL);
	assign rs_n = (rem0 >= 17'(DEG_FULL)) ? 9'(rem0 - 17'(DEG_FULL)) : 9'(rem0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2 <= pl_s1;
			rs_s2 <= rs_n;
			rc_s2 <= (rs_n >= 9'(DEG_FULL - DEG_QUART)) ? rs_n - 9'(DEG_FULL - DEG_QUART)
			                                             : rs_n + 9'(DEG_QUART);
		end
	end

	// stage 3: fold into the first half turn, x = r*(180-r), lane 0 sine, lane 1 cosine
	logic        v_s3;
	item_t       pl_s3;
	logic [12:0] x_s3   [2];
	logic        neg_s3 [2];
	logic [8:0]  rl     [2];
	logic [7:0]  rf     [2];

	assign rl[0] = rs_s2;
	assign rl[1] = rc_s2;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rf[l] = (rl[l] >= 9'(DEG_HALF)) ? 8'(rl[l] - 9'(DEG_HALF)) : 8'(rl[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s3 <= pl_s2;
			for (int l = 0; l < 2; l++) begin
				neg_s3[l] <= (rl[l] >= 9'(DEG_HALF));
				x_s3[l]   <= 13'(rf[l]) * (13'(DEG_HALF) - 13'(rf[l]));
			end
		end
	end

	// divider stages: index 0 holds numerator and denominator, each later one a quotient bit
	logic        dv_s   [DIV_STAGES+1];
	item_t       dpl_s  [DIV_STAGES+1];
	logic [24:0] drem_s [DIV_STAGES+1][2];
	logic [15:0] dden_s [DIV_STAGES+1][2];
	logic [10:0] dq_s   [DIV_STAGES+1][2];
	logic        dneg_s [DIV_STAGES+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= DIV_STAGES; j++) dv_s[j] <= 1'b0;
		end else if (en) begin
			dv_s[0] <= v_s3;
			for (int j = 0; j < DIV_STAGES; j++) dv_s[j+1] <= dv_s[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dpl_s[0] <= pl_s3;
			for (int l = 0; l < 2; l++) begin
				drem_s[0][l] <= {x_s3[l], 12'd0};
				dden_s[0][l] <= 16'(BHASK_C) - 16'(x_s3[l]);
				dq_s[0][l]   <= '0;
				dneg_s[0][l] <= neg_s3[l];
			end
			for (int j = 0; j < DIV_STAGES; j++) begin
				dpl_s[j+1] <= dpl_s[j];
				for (int l = 0; l < 2; l++) begin
					dden_s[j+1][l] <= dden_s[j][l];
					dneg_s[j+1][l] <= dneg_s[j][l];
					if ({1'b0, drem_s[j][l]} >= (26'(dden_s[j][l]) << (QBITS - 1 - j))) begin
						drem_s[j+1][l] <= 25'({1'b0, drem_s[j][l]}
						                  - (26'(dden_s[j][l]) << (QBITS - 1 - j)));
						dq_s[j+1][l]   <= dq_s[j][l] | (11'd1 << (QBITS - 1 - j));
					end else begin
						drem_s[j+1][l] <= drem_s[j][l];
						dq_s[j+1][l]   <= dq_s[j][l];
					end
				end
			end
		end
	end

	// stage m1: signed sine/cosine, length products
	logic               v_m1;
	item_t              pl_m1;
	logic signed [11:0] sv_m1, cv_m1;
	logic signed [23:0] px_m1, py_m1;
	logic signed [11:0] sv_n, cv_n;

	assign sv_n = dneg_s[DIV_STAGES][0] ? -$signed({1'b0, dq_s[DIV_STAGES][0]})
	                                    :  $signed({1'b0, dq_s[DIV_STAGES][0]});
	assign cv_n = dneg_s[DIV_STAGES][1] ? -$signed({1'b0, dq_s[DIV_STAGES][1]})
	                                    :  $signed({1'b0, dq_s[DIV_STAGES][1]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m1 <= 1'b0;
		else if (en) v_m1 <= dv_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_m1 <= dpl_s[DIV_STAGES];
			sv_m1 <= sv_n;
			cv_m1 <= cv_n;
			px_m1 <= $signed({1'b0, dpl_s[DIV_STAGES].len}) * 24'(sv_n);
			py_m1 <= $signed({1'b0, dpl_s[DIV_STAGES].len}) * 24'(-cv_n);
		end
	end

	// stage m2: hand tip
	logic               v_m2;
	item_t              pl_m2;
	logic signed [11:0] sv_m2, cv_m2;
	logic signed [13:0] tx_m2, ty_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_m2 <= 1'b0;
		else if (en) v_m2 <= v_m1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_m2 <= pl_m1;
			sv_m2 <= sv_m1;
			cv_m2 <= cv_m1;
			tx_m2 <= $signed({2'b00, pl_m1.cx}) + trunc_q10(px_m1);
			ty_m2 <= $signed({2'b00, pl_m1.cy}) + trunc_q10(py_m1);
		end
	end

	// segment emitter: holds one hand and steps k
	logic               busy_q;
	logic signed [3:0]  k_q;
	item_t              pl_q;
	logic signed [11:0] sv_q, cv_q;
	logic signed [13:0] tx_q, ty_q;
	logic               ov_q;
	logic               emit;
	logic               is_last;
	logic signed [13:0] ox, oy;

	assign en      = !(v_m2 && busy_q);
	assign in_ready = en;
	assign emit    = busy_q && (!ov_q || out_ready);
	assign is_last = (k_q == $signed({1'b0, pl_q.half}));
	assign ox      = trunc_q10(24'(k_q) * 24'(cv_q));
	assign oy      = trunc_q10(24'(k_q) * 24'(sv_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (!busy_q) busy_q <= v_m2;
			else if (emit && is_last) busy_q <= 1'b0;
			if (emit) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			pl_q <= pl_m2;
			sv_q <= sv_m2;
			cv_q <= cv_m2;
			tx_q <= tx_m2;
			ty_q <= ty_m2;
			k_q  <= -$signed({1'b0, pl_m2.half});
		end else if (emit) begin
			k_q <= k_q + 4'sd1;
		end
		if (emit) begin
			start_x        <= $signed({2'b00, pl_q.cx}) + ox;
			start_y        <= $signed({2'b00, pl_q.cy}) + oy;
			end_x          <= tx_q + ox;
			end_y          <= ty_q + oy;
			segment_colour <= pl_q.colour;
			last_segment   <= is_last;
		end
	end

	assign out_valid = ov_q;

	// checks
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (k_q <= $signed({1'b0, pl_q.half})))
		else $error("offset index past the last segment");

	a_load_k: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && v_m2) |=> (busy_q && k_q == -$signed({1'b0, pl_q.half})))
		else $error("emitter did not start at the first offset");

	a_q_max: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s[DIV_STAGES] |-> (dq_s[DIV_STAGES][0] <= 11'd1024 && dq_s[DIV_STAGES][1] <= 11'd1024))
		else $error("sine quotient out of range");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(tx_m2) && v_m2)
		else $error("front pipeline moved while stalled");

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the clock hand segment generator: directed and random hands checked against a segment predictor
`timescale 1ns / 1ps
module tb_top
	import chsg_pkg::*;
;

	// one expected segment word
	typedef struct {
		logic signed [13:0] sx, sy, ex, ey;
		logic [31:0] colour;
		logic last;
	} segment_t;

	// predicts segments per hand and checks them in order
	class segment_board;
		segment_t pending[$];
		int errors;

		function int bhaskara_q10(int r);
			int neg, x, mag;
			neg = 0;
			if (r >= int'(DEG_HALF)) begin
				r = r - int'(DEG_HALF);
				neg = 1;
			end
			x = r * (int'(DEG_HALF) - r);
			mag = (4 * x * 1024) / (int'(BHASK_C) - x);
			return neg ? -mag : mag;
		endfunction

		function void note_hand(logic [11:0] cx, logic [11:0] cy, logic [10:0] len,
				logic signed [15:0] ang, logic [3:0] thick, logic [31:0] col);
			int r, sv, cv, tx, ty, h, ox, oy, l, xi, yi;
			segment_t s;
			xi = cx;
			yi = cy;
			l = len;
			r = int'(ang) % int'(DEG_FULL);
			if (r < 0) r += int'(DEG_FULL);
			sv = bhaskara_q10(r);
			cv = bhaskara_q10((r + int'(DEG_QUART)) % int'(DEG_FULL));
			tx = xi + (l * sv) / 1024;
			ty = yi + (l * -cv) / 1024;
			h = thick / 2;
			for (int k = -h; k <= h; k++) begin
				ox = (k * cv) / 1024;
				oy = (k * sv) / 1024;
				s.sx = 14'(xi + ox);
				s.sy = 14'(yi + oy);
				s.ex = 14'(tx + ox);
				s.ey = 14'(ty + oy);
				s.colour = col;
				s.last = (k == h);
				pending.push_back(s);
			end
		endfunction

		function void check_segment(segment_t got);
			segment_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected segment sx=%0d sy=%0d", $time, got.sx, got.sy);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
					got.ey !== want.ey || got.colour !== want.colour ||
					got.last !== want.last) begin
				$display("%0t: mismatch expected %0d %0d %0d %0d %h %b actual %0d %0d %0d %0d %h %b",
					$time, want.sx, want.sy, want.ex, want.ey, want.colour, want.last,
					got.sx, got.sy, got.ex, got.ey, got.colour, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, in_valid, in_ready, out_valid, out_ready, last_segment;
	logic [11:0] centre_x, centre_y;
	logic [10:0] hand_length;
	logic signed [15:0] angle_deg;
	logic [3:0] thickness;
	logic [31:0] line_colour, segment_colour;
	logic signed [13:0] start_x, start_y, end_x, end_y;
	segment_board board;
	bit quiet;

	clock_hand_segment_generator uut (.*);

	initial clk = 0;
	always #5 clk = ~clk;

	// drive one hand word and wait for acceptance
	task send_hand(logic [11:0] cx, logic [11:0] cy, logic [10:0] len,
			logic signed [15:0] ang, logic [3:0] thick, logic [31:0] col);
		while (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		centre_x <= cx; centre_y <= cy; hand_length <= len;
		angle_deg <= ang; thickness <= thick; line_colour <= col;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_hand(cx, cy, len, ang, thick, col);
	endtask

	task send_random();
		send_hand(12'($urandom), 12'($urandom),
			($urandom_range(3) == 0) ? 11'h7FF : 11'($urandom),
			16'($urandom), 4'($urandom), $urandom);
	endtask

	// receiver with random stalls; checks every accepted segment word
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_segment('{start_x, start_y, end_x, end_y, segment_colour, last_segment});
		out_ready <= quiet || ($urandom_range(99) >= 9);
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int waited;
		board = new();
		quiet = 0;
		arst_n = 0; in_valid = 0;
		centre_x = 0; centre_y = 0; hand_length = 0; angle_deg = 0;
		thickness = 0; line_colour = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, negative angles, zero length, thin hands
		send_hand(12'd0, 12'd0, 11'd0, 16'sd0, 4'd0, 32'd0);
		send_hand(12'hFFF, 12'hFFF, 11'h7FF, 16'sh7FFF, 4'd15, 32'hFFFFFFFF);
		send_hand(12'd2048, 12'd2048, 11'h7FF, 16'sh8000, 4'd14, 32'h12345678);
		send_hand(12'd100, 12'd200, 11'd500, -16'sd90, 4'd1, 32'hA5A5A5A5);
		send_hand(12'd0, 12'd4095, 11'd2047, 16'sd90, 4'd15, 32'd1);
		send_hand(12'd4095, 12'd0, 11'd2047, 16'sd180, 4'd15, 32'd2);
		send_hand(12'd0, 12'd0, 11'd2047, 16'sd270, 4'd15, 32'd3);
		send_hand(12'd500, 12'd500, 11'd0, 16'sd45, 4'd7, 32'd4);
		send_hand(12'd300, 12'd300, 11'd300, 16'sd359, 4'd2, 32'd5);
		send_hand(12'd300, 12'd300, 11'd300, 16'sd360, 4'd3, 32'd6);
		send_hand(12'd300, 12'd300, 11'd300, -16'sd1, 4'd8, 32'd7);
		send_hand(12'd300, 12'd300, 11'd300, -16'sd360, 4'd9, 32'd8);
		send_hand(12'd1, 12'd2, 11'd1000, 16'sd1, 4'd13, 32'h5A5A5A5A);
		// pause until all segments drained
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		// random, first stretch without idling
		quiet = 1;
		repeat (80) send_random();
		quiet = 0;
		repeat (330) send_random();
		in_valid <= 0;
		waited = 0;
		while (board.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
